@@ rtl/core/dl_pkg.sv @@
// shared constants, types and the sigmoid table of the dense layer
package dl_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;

    localparam int IDX_W     = 6;
    localparam int X_AW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int COL_AW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int W_DEPTH   = MAX_INPUTS * MAX_OUTPUTS;
    localparam int W_AW      = $clog2(W_DEPTH);
    localparam int CNT_IN_W  = $clog2(MAX_INPUTS + 1);
    localparam int CNT_OUT_W = $clog2(MAX_OUTPUTS + 1);
    localparam int ACC_W     = 2 * DATA_WIDTH + X_AW;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int TAB_W     = 12;
    localparam int SEG_W     = 5;
    localparam int SEG_F_W   = 11;
    localparam int MAG_W     = SEG_W + SEG_F_W;

    localparam int S_TDATA_W = ((2 * IDX_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + DATA_WIDTH + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] ACT_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] ACT_SIGMOID = 2'd1;
    localparam logic [MODE_W-1:0] ACT_TANH    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_OUTPUTS = 2'd2;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1 << FRAC_BITS);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_PUSH
    } seq_state_t;

    // logistic function at k/2 in q.12
    function automatic logic [TAB_W-1:0] sig_tab(input logic [SEG_W-1:0] k);
        logic [TAB_W-1:0] t;
        case (k)
            5'd0:    t = 12'd2048;
            5'd1:    t = 12'd2550;
            5'd2:    t = 12'd2994;
            5'd3:    t = 12'd3349;
            5'd4:    t = 12'd3608;
            5'd5:    t = 12'd3785;
            5'd6:    t = 12'd3902;
            5'd7:    t = 12'd3976;
            5'd8:    t = 12'd4022;
            5'd9:    t = 12'd4051;
            5'd10:   t = 12'd4069;
            5'd11:   t = 12'd4079;
            5'd12:   t = 12'd4086;
            5'd13:   t = 12'd4090;
            5'd14:   t = 12'd4092;
            5'd15:   t = 12'd4094;
            default: t = 12'd4095;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/core/dl_store.sv @@
// weight memory and input vector memory with registered reads
module dl_store
    import dl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         w_we,
    input  logic [W_AW-1:0]              w_waddr,
    input  logic signed [DATA_WIDTH-1:0] w_wdata,
    input  logic                         x_we,
    input  logic [X_AW-1:0]              x_waddr,
    input  logic signed [DATA_WIDTH-1:0] x_wdata,
    input  logic                         rd_en,
    input  logic [W_AW-1:0]              w_raddr,
    input  logic [X_AW-1:0]              x_raddr,
    output logic signed [DATA_WIDTH-1:0] w_rdata,
    output logic signed [DATA_WIDTH-1:0] x_rdata
);

    logic signed [DATA_WIDTH-1:0] w_mem [W_DEPTH];
    logic signed [DATA_WIDTH-1:0] x_mem [MAX_INPUTS];
    logic [MAX_INPUTS-1:0]        x_vld_reg;
    logic signed [DATA_WIDTH-1:0] w_q_reg;
    logic signed [DATA_WIDTH-1:0] x_q_reg;
    logic                         x_hit_reg;
    logic                         x_bias_reg;

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (rd_en)
        begin
            w_q_reg <= w_mem[w_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[x_waddr] <= x_wdata;
        end
        if (rd_en)
        begin
            x_q_reg    <= x_mem[x_raddr];
            x_hit_reg  <= x_vld_reg[x_raddr];
            x_bias_reg <= (x_raddr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= '0;
        end
        else if (x_we)
        begin
            x_vld_reg[x_waddr] <= 1'b1;
        end
    end

    // bias position reads as 1.0, unwritten positions as zero
    assign w_rdata = w_q_reg;
    assign x_rdata = x_bias_reg ? ONE_Q : (x_hit_reg ? x_q_reg : '0);

endmodule

@@ rtl/core/dl_mac.sv @@
// shared multiply-accumulate unit
module dl_mac
    import dl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mac_op_t                      op,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic                         acc_valid,
    output logic signed [ACC_W-1:0]      acc
);

    mac_op_t                        op1_reg;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            op1_reg  <= op;
            done_reg <= op1_reg.valid & op1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (op1_reg.valid)
        begin
            if (op1_reg.first)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc_valid = done_reg;
    assign acc       = acc_reg;

endmodule

@@ rtl/core/dl_act.sv @@
// rounding, saturation and table sigmoid / tanh in three stages
module dl_act
    import dl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [ACC_W-1:0]      acc,
    input  logic [MODE_W-1:0]            mode,
    output logic                         res_valid,
    output logic signed [DATA_WIDTH-1:0] res
);

    localparam logic signed [ACC_W-1:0] HALF_LIN  = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_TANH = ACC_W'(1) <<< (FRAC_BITS - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MAG_CAP   = ACC_W'(1 << (MAG_W - 1));

    logic signed [ACC_W-1:0]      x_lin;
    logic signed [ACC_W-1:0]      x_tanh;
    logic signed [ACC_W-1:0]      x;
    logic signed [ACC_W-1:0]      x_abs;
    logic [MAG_W-1:0]             mag;
    logic signed [DATA_WIDTH-1:0] lin;

    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic                         neg1_reg;
    logic                         neg2_reg;
    logic [SEG_W-1:0]             seg1_reg;
    logic [SEG_F_W-1:0]           f1_reg;
    logic signed [DATA_WIDTH-1:0] lin1_reg;
    logic signed [DATA_WIDTH-1:0] lin2_reg;
    logic [MODE_W-1:0]            mode1_reg;
    logic [MODE_W-1:0]            mode2_reg;
    logic [TAB_W-1:0]             y2_reg;
    logic signed [DATA_WIDTH-1:0] res_reg;

    logic [TAB_W-1:0]             t0;
    logic [TAB_W-1:0]             t1;
    logic [TAB_W+SEG_F_W-1:0]     lerp;
    logic [TAB_W-1:0]             y;
    logic [TAB_W:0]               s;
    logic signed [DATA_WIDTH-1:0] s_ext;
    logic signed [DATA_WIDTH-1:0] res_next;

    // stage 1: round to q4.12 (or 2x for tanh), clamp and split magnitude
    always_comb
    begin
        x_lin  = (acc + HALF_LIN) >>> FRAC_BITS;
        x_tanh = (acc + HALF_TANH) >>> (FRAC_BITS - 1);
        x      = (mode == ACT_TANH) ? x_tanh : x_lin;
        if (x_lin > SAT_HI)
        begin
            lin = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (x_lin < SAT_LO)
        begin
            lin = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            lin = x_lin[DATA_WIDTH-1:0];
        end
        x_abs = x[ACC_W-1] ? -x : x;
        mag   = (x_abs > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : x_abs[MAG_W-1:0];
    end

    // stage 2: linear interpolation between table points
    always_comb
    begin
        t0   = sig_tab(seg1_reg);
        t1   = sig_tab(seg1_reg + SEG_W'(1));
        lerp = (TAB_W+SEG_F_W)'(t1 - t0) * (TAB_W+SEG_F_W)'(f1_reg)
               + (TAB_W+SEG_F_W)'(1 << (SEG_F_W - 1));
        if (seg1_reg >= SEG_W'(16))
        begin
            y = sig_tab(SEG_W'(16));
        end
        else
        begin
            y = t0 + TAB_W'(lerp >> SEG_F_W);
        end
    end

    // stage 3: mirror for negative inputs and pick the output form
    always_comb
    begin
        s     = neg2_reg ? ((TAB_W+1)'(1 << FRAC_BITS) - (TAB_W+1)'(y2_reg))
                         : (TAB_W+1)'(y2_reg);
        s_ext = DATA_WIDTH'(s);
        case (mode2_reg)
            ACT_LINEAR: res_next = lin2_reg;
            ACT_TANH:   res_next = (s_ext <<< 1) - ONE_Q;
            default:    res_next = s_ext;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg1_reg  <= x[ACC_W-1];
            seg1_reg  <= mag[MAG_W-1:SEG_F_W];
            f1_reg    <= mag[SEG_F_W-1:0];
            lin1_reg  <= lin;
            mode1_reg <= mode;
        end
        if (v1_reg)
        begin
            neg2_reg  <= neg1_reg;
            y2_reg    <= y;
            lin2_reg  <= lin1_reg;
            mode2_reg <= mode1_reg;
        end
        if (v2_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = v3_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/dl_seq.sv @@
// sequencer walking rows and columns through the shared mac
module dl_seq
    import dl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNT_IN_W-1:0]  n_in,
    input  logic [CNT_OUT_W-1:0] n_out,
    input  logic                 act_done,
    input  logic                 out_free,
    output logic                 idle,
    output logic                 rd_en,
    output logic [W_AW-1:0]      w_raddr,
    output logic [X_AW-1:0]      x_raddr,
    output mac_op_t              op,
    output logic                 push,
    output logic [COL_AW-1:0]    res_index,
    output logic                 res_last
);

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [X_AW-1:0]     i_reg;
    logic [X_AW-1:0]     i_next;
    logic [COL_AW-1:0]   j_reg;
    logic [COL_AW-1:0]   j_next;
    mac_op_t             op_reg;
    mac_op_t             op_next;
    logic                row_last;
    logic                col_last;

    assign row_last = (CNT_IN_W'(i_reg) == n_in - CNT_IN_W'(1));
    assign col_last = (CNT_OUT_W'(j_reg) == n_out - CNT_OUT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        op_next    = '0;
        rd_en      = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                op_next.valid = 1'b1;
                op_next.first = (i_reg == '0);
                op_next.last  = row_last;
                if (row_last)
                begin
                    i_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    i_next = i_reg + X_AW'(1);
                end
            end
            ST_WAIT:
            begin
                if (act_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    if (col_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + COL_AW'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign w_raddr   = W_AW'(int'(i_reg) * MAX_OUTPUTS + int'(j_reg));
    assign x_raddr   = i_reg;
    assign op        = op_reg;
    assign res_index = j_reg;
    assign res_last  = col_last;

endmodule

@@ rtl/core/dense_layer_with_activation.sv @@
// top level of the fully connected layer with selectable activation
//
// input channel s_*: one item is either a weight (tuser = 0) written to the
// weight memory at (row, column), or a feature (tuser = 1) written to input
// position row; position 0 is the fixed bias 1.0 and ignores features.
// a feature with tlast set starts a run over all active output columns.
// output channel m_*: one item per active column, in column order, with
// tlast on the final column.
// weight items and features without tlast are taken whenever the block is
// idle. in a run each column streams its rows through the single shared
// mac, one row per cycle, then passes through the mac tail, the three-stage
// activation unit and the hand-off to the output register. s_tready is low
// for the whole run. a stalled output holds the next column until the
// register is taken.
// reset clears the control state, the input vector to bias only and the
// configuration to sigmoid with 64 inputs and 64 outputs; the weight memory
// is not cleared and must be loaded before use.
// cfg_we writes register cfg_index (0 mode, 1 inputs, 2 outputs) at once
module dense_layer_with_activation
    import dl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row_index, column_index, value
    input  logic [0:0]           s_tuser,   // kind
    input  logic                 s_tlast,   // last_feature
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_index, out_value
    output logic                 m_tlast,   // out_last
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [MODE_W-1:0]            act_mode_reg;
    logic [CFG_W-1:0]             active_inputs_reg;
    logic [CFG_W-1:0]             active_outputs_reg;
    logic [CNT_IN_W-1:0]          n_in;
    logic [CNT_OUT_W-1:0]         n_out;

    logic                         in_kind;
    logic [IDX_W-1:0]             in_row;
    logic [IDX_W-1:0]             in_col;
    logic signed [DATA_WIDTH-1:0] in_value;
    logic                         accept;
    logic                         w_we;
    logic                         x_we;
    logic                         start;

    logic                         idle;
    logic                         rd_en;
    logic [W_AW-1:0]              w_raddr;
    logic [X_AW-1:0]              x_raddr;
    logic signed [DATA_WIDTH-1:0] w_rdata;
    logic signed [DATA_WIDTH-1:0] x_rdata;
    mac_op_t                      op;
    logic                         acc_valid;
    logic signed [ACC_W-1:0]      acc;
    logic                         res_valid;
    logic signed [DATA_WIDTH-1:0] res;
    logic                         push;
    logic [COL_AW-1:0]            res_index;
    logic                         res_last;
    logic                         out_free;

    logic                         out_valid_reg;
    logic [IDX_W-1:0]             out_index_reg;
    logic signed [DATA_WIDTH-1:0] out_value_reg;
    logic                         out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_mode_reg       <= ACT_SIGMOID;
            active_inputs_reg  <= CFG_W'(MAX_INPUTS);
            active_outputs_reg <= CFG_W'(MAX_OUTPUTS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACT_MODE:       act_mode_reg       <= cfg_data[MODE_W-1:0];
                REG_ACTIVE_INPUTS:  active_inputs_reg  <= cfg_data;
                REG_ACTIVE_OUTPUTS: active_outputs_reg <= cfg_data;
                default:            act_mode_reg       <= act_mode_reg;
            endcase
        end
    end

    // counts clamp to 1 .. maximum
    always_comb
    begin
        if (active_inputs_reg == '0)
        begin
            n_in = CNT_IN_W'(1);
        end
        else if (int'(active_inputs_reg) > MAX_INPUTS)
        begin
            n_in = CNT_IN_W'(MAX_INPUTS);
        end
        else
        begin
            n_in = CNT_IN_W'(active_inputs_reg);
        end
        if (active_outputs_reg == '0)
        begin
            n_out = CNT_OUT_W'(1);
        end
        else if (int'(active_outputs_reg) > MAX_OUTPUTS)
        begin
            n_out = CNT_OUT_W'(MAX_OUTPUTS);
        end
        else
        begin
            n_out = CNT_OUT_W'(active_outputs_reg);
        end
    end

    assign in_kind  = s_tuser[0];
    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W];

    assign s_tready = idle;
    assign accept   = s_tvalid & s_tready;
    assign w_we     = accept && (in_kind == KIND_WEIGHT)
                      && (int'(in_row) < MAX_INPUTS) && (int'(in_col) < MAX_OUTPUTS);
    assign x_we     = accept && (in_kind == KIND_FEATURE)
                      && (in_row != '0) && (int'(in_row) < MAX_INPUTS);
    assign start    = accept && (in_kind == KIND_FEATURE) && s_tlast;

    dl_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .w_we    (w_we),
        .w_waddr (W_AW'(int'(in_row) * MAX_OUTPUTS + int'(in_col))),
        .w_wdata (in_value),
        .x_we    (x_we),
        .x_waddr (X_AW'(in_row)),
        .x_wdata (in_value),
        .rd_en   (rd_en),
        .w_raddr (w_raddr),
        .x_raddr (x_raddr),
        .w_rdata (w_rdata),
        .x_rdata (x_rdata)
    );

    dl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .n_in      (n_in),
        .n_out     (n_out),
        .act_done  (res_valid),
        .out_free  (out_free),
        .idle      (idle),
        .rd_en     (rd_en),
        .w_raddr   (w_raddr),
        .x_raddr   (x_raddr),
        .op        (op),
        .push      (push),
        .res_index (res_index),
        .res_last  (res_last)
    );

    dl_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .a         (x_rdata),
        .b         (w_rdata),
        .acc_valid (acc_valid),
        .acc       (acc)
    );

    dl_act u_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (acc_valid),
        .acc       (acc),
        .mode      (act_mode_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_index_reg <= IDX_W'(res_index);
            out_value_reg <= res;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_value_reg, out_index_reg});
    assign m_tlast  = out_last_reg;

endmodule

@@ dv/tb.sv @@
// self-checking testbench of the dense layer with its activation stage
`timescale 1ns / 100ps

module tb
    import dl_pkg::*;
();

    localparam int TIMEOUT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
    } neuron_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // layer state as the block should hold it
    logic signed [DATA_WIDTH-1:0] weight_mem [MAX_INPUTS][MAX_OUTPUTS];
    bit                           weight_set [MAX_INPUTS][MAX_OUTPUTS];
    logic signed [DATA_WIDTH-1:0] feature_vec [MAX_INPUTS];
    logic [MODE_W-1:0]            act_mode    = ACT_SIGMOID;
    logic [CFG_W-1:0]             n_in_reg    = 7'd64;
    logic [CFG_W-1:0]             n_out_reg   = 7'd64;

    int sig_pts [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                         4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

    neuron_t neuron_q [$];
    int      err_cnt       = 0;
    int      items_sent    = 0;
    int      cycle_cnt     = 0;
    int      send_idle_pct = 15;
    int      recv_idle_pct = 69;

    dense_layer_with_activation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (feature_vec[i])
            feature_vec[i] = '0;
        feature_vec[0] = ONE_Q;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > TIMEOUT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic int eff_count(input logic [CFG_W-1:0] v, input int max_n);
        if (v < 1)
            return 1;
        if (v > max_n)
            return max_n;
        return v;
    endfunction

    function automatic longint logistic_q(input longint x);
        longint a;
        longint y;
        int     seg;
        int     f;
        a = (x < 0) ? -x : x;
        if (a > 32768)
            a = 32768;
        seg = int'(a >> 11);
        f   = int'(a & 2047);
        if (seg >= 16)
            y = sig_pts[16];
        else
            y = sig_pts[seg] + (((sig_pts[seg + 1] - sig_pts[seg]) * f + 1024) >> 11);
        return (x < 0) ? 4096 - y : y;
    endfunction

    function automatic void predict_outputs();
        int      n_in;
        int      n_out;
        longint  acc;
        longint  r;
        neuron_t n;
        n_in  = eff_count(n_in_reg, MAX_INPUTS);
        n_out = eff_count(n_out_reg, MAX_OUTPUTS);
        for (int j = 0; j < n_out; j++)
        begin
            acc = 0;
            for (int i = 0; i < n_in; i++)
                acc += longint'(feature_vec[i]) * longint'(weight_mem[i][j]);
            if (act_mode == ACT_LINEAR)
            begin
                r = (acc + 2048) >>> FRAC_BITS;
                if (r > 32767)
                    r = 32767;
                else if (r < -32768)
                    r = -32768;
            end
            else if (act_mode == ACT_TANH)
                r = 2 * logistic_q((acc + 1024) >>> (FRAC_BITS - 1)) - 4096;
            else
                r = logistic_q((acc + 2048) >>> FRAC_BITS);
            n.index = IDX_W'(j);
            n.value = DATA_WIDTH'(r);
            n.last  = (j == n_out - 1);
            neuron_q.push_back(n);
        end
    endfunction

    function automatic void layer_accept(input logic kind, input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [DATA_WIDTH-1:0] value, input logic last);
        if (kind == KIND_WEIGHT)
        begin
            weight_mem[row][col] = value;
            weight_set[row][col] = 1'b1;
        end
        else
        begin
            if (row != 0)
                feature_vec[row] = value;
            if (last)
                predict_outputs();
        end
    endfunction

    function automatic bit weights_ready();
        for (int i = 0; i < eff_count(n_in_reg, MAX_INPUTS); i++)
            for (int j = 0; j < eff_count(n_out_reg, MAX_OUTPUTS); j++)
                if (!weight_set[i][j])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_value();
        if ($urandom_range(3) == 0)
            return DATA_WIDTH'($urandom);
        return DATA_WIDTH'($urandom_range(8191) - 4096);
    endfunction

    always @(posedge clk)
    begin : out_check
        neuron_t exp_n;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (neuron_q.size() == 0)
            begin
                $error("unexpected output item, out_index %0d", m_tdata[IDX_W-1:0]);
                err_cnt++;
            end
            else
            begin
                exp_n = neuron_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== exp_n.index)
                begin
                    $error("out_index: expected %0d, got %0d", exp_n.index,
                           m_tdata[IDX_W-1:0]);
                    err_cnt++;
                end
                if (m_tdata[IDX_W +: DATA_WIDTH] !== exp_n.value)
                begin
                    $error("out_value: expected %0d, got %0d", $signed(exp_n.value),
                           $signed(m_tdata[IDX_W +: DATA_WIDTH]));
                    err_cnt++;
                end
                if (m_tlast !== exp_n.last)
                begin
                    $error("out_last: expected %0d, got %0d", exp_n.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic [DATA_WIDTH-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, col, row});
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        layer_accept(kind, row, col, value, last);
        items_sent++;
    endtask

    task automatic load_weight(input int row, input int col, input logic [DATA_WIDTH-1:0] value);
        send_item(KIND_WEIGHT, IDX_W'(row), IDX_W'(col), value, 1'b0);
    endtask

    task automatic feed(input int row, input logic [DATA_WIDTH-1:0] value, input logic last);
        send_item(KIND_FEATURE, IDX_W'(row), IDX_W'($urandom_range(63)), value, last);
    endtask

    // load every weight of the active window that has never been written
    task automatic fill_weights();
        for (int i = 0; i < eff_count(n_in_reg, MAX_INPUTS); i++)
            for (int j = 0; j < eff_count(n_out_reg, MAX_OUTPUTS); j++)
                if (!weight_set[i][j])
                    load_weight(i, j, rand_value());
    endtask

    task automatic drain_layer();
        s_tvalid <= 1'b0;
        while (neuron_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ACT_MODE:       act_mode  = data[MODE_W-1:0];
            REG_ACTIVE_INPUTS:  n_in_reg  = data;
            REG_ACTIVE_OUTPUTS: n_out_reg = data;
            default:            ;
        endcase
        @(posedge clk);
    endtask

    // mode left at its reset value, feature on the bias row starts the run
    task automatic test_bias_row();
        write_cfg(REG_ACTIVE_INPUTS, 7'd1);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd3);
        load_weight(0, 0, 16'h7fff);
        load_weight(0, 1, 16'h8000);
        load_weight(0, 2, 16'h0000);
        feed(0, 16'h1234, 1'b1);
        drain_layer();
    endtask

    task automatic test_linear_saturation();
        write_cfg(REG_ACT_MODE, ACT_LINEAR);
        write_cfg(REG_ACTIVE_INPUTS, 7'd3);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd2);
        load_weight(0, 0, 16'h0000);
        load_weight(0, 1, 16'h8000);
        load_weight(1, 0, 16'h7fff);
        load_weight(1, 1, 16'h8000);
        load_weight(2, 0, 16'h7fff);
        load_weight(2, 1, 16'h7fff);
        // weight with a last mark emits nothing
        send_item(KIND_WEIGHT, 6'd1, 6'd1, 16'h8000, 1'b1);
        feed(1, 16'h7fff, 1'b0);
        feed(2, 16'h8000, 1'b1);
        feed(2, 16'h7fff, 1'b1);
        feed(1, 16'h8000, 1'b1);
        drain_layer();
    endtask

    task automatic test_tanh_and_spare_code();
        write_cfg(REG_ACT_MODE, ACT_TANH);
        feed(1, 16'h0800, 1'b1);
        drain_layer();
        write_cfg(REG_ACT_MODE, 2'd3);
        feed(2, 16'hf000, 1'b1);
        drain_layer();
    endtask

    task automatic test_rows_beyond_active();
        write_cfg(REG_ACT_MODE, ACT_SIGMOID);
        feed(5, 16'h2000, 1'b0);
        n_in_reg = 7'd6;
        fill_weights();
        n_in_reg = 7'd3;
        feed(1, 16'h0400, 1'b1);
        drain_layer();
        write_cfg(REG_ACTIVE_INPUTS, 7'd6);
        feed(2, 16'h0c00, 1'b1);
        drain_layer();
    endtask

    task automatic test_count_extremes();
        write_cfg(REG_ACT_MODE, ACT_LINEAR);
        write_cfg(REG_ACTIVE_INPUTS, 7'd64);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd1);
        fill_weights();
        feed(63, 16'h0800, 1'b1);
        drain_layer();
        write_cfg(REG_ACTIVE_INPUTS, 7'd1);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd64);
        fill_weights();
        feed(0, 16'h0000, 1'b1);
        drain_layer();
        write_cfg(REG_ACT_MODE, ACT_SIGMOID);
        write_cfg(REG_ACTIVE_INPUTS, 7'd0);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd127);
        feed(0, 16'hffff, 1'b1);
        drain_layer();
        write_cfg(REG_ACTIVE_INPUTS, 7'd127);
        write_cfg(REG_ACTIVE_OUTPUTS, 7'd0);
        feed(33, 16'h8000, 1'b1);
        drain_layer();
    endtask

    task automatic test_random(input int quota, input int tx_pct, input int rx_pct);
        int start;
        int r;
        int n_in;
        int n_out;
        logic [CFG_W-1:0] in_v;
        logic [CFG_W-1:0] out_v;
        start         = items_sent;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        while (items_sent - start < quota)
        begin
            drain_layer();
            r = $urandom_range(9);
            if (r == 0)
            begin
                in_v  = CFG_W'($urandom_range(9, 127));
                out_v = CFG_W'($urandom_range(0, 1));
            end
            else if (r == 1)
            begin
                in_v  = CFG_W'($urandom_range(0, 1));
                out_v = CFG_W'($urandom_range(9, 127));
            end
            else
            begin
                in_v  = CFG_W'($urandom_range(0, 8));
                out_v = CFG_W'($urandom_range(0, 8));
            end
            write_cfg(REG_ACT_MODE, MODE_W'($urandom_range(3)));
            write_cfg(REG_ACTIVE_INPUTS, in_v);
            write_cfg(REG_ACTIVE_OUTPUTS, out_v);
            n_in  = eff_count(n_in_reg, MAX_INPUTS);
            n_out = eff_count(n_out_reg, MAX_OUTPUTS);
            repeat ($urandom_range(1, 4))
            begin
                fill_weights();
                repeat ($urandom_range(0, 3))
                    load_weight($urandom_range(n_in - 1), $urandom_range(n_out - 1),
                                rand_value());
                // noise: stray weights, stray features
                repeat ($urandom_range(0, 2))
                begin
                    if ($urandom_range(1))
                        send_item(KIND_WEIGHT, IDX_W'($urandom_range(63)),
                                  IDX_W'($urandom_range(63)), rand_value(),
                                  1'($urandom_range(1)));
                    else
                        feed($urandom_range(63), rand_value(), 1'b0);
                end
                repeat ($urandom_range(0, (n_in < 8) ? n_in : 8))
                begin
                    if ($urandom_range(9) == 0)
                        feed($urandom_range(63), rand_value(), 1'b0);
                    else
                        feed($urandom_range(n_in - 1), rand_value(), 1'b0);
                end
                if (weights_ready())
                    feed($urandom_range(63), rand_value(), 1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bias_row();
        test_linear_saturation();
        test_tanh_and_spare_code();
        test_rows_beyond_active();
        test_count_extremes();
        test_random(50, 15, 69);
        test_random(50, 69, 15);
        test_random(50, 0, 0);
        drain_layer();
        repeat (20) @(posedge clk);
        if (neuron_q.size() != 0)
        begin
            $error("%0d expected output items never arrived", neuron_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dl_pkg.sv
rtl/core/dl_store.sv
rtl/core/dl_mac.sv
rtl/core/dl_act.sv
rtl/core/dl_seq.sv
rtl/core/dense_layer_with_activation.sv
dv/tb.sv
